// File: design/first_fit_free_list_allocator_top_assert.svh
// assertion macros for the first-fit allocator
// included by first_fit_free_list_allocator_top.sv, no other dependencies
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FFA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("ffa: implication check failed");
// next-cycle implication
`define FFA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("ffa: next-cycle check failed");
`else
`define FFA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define FFA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// File: design/ffa_pkg.sv
// shared types and codes of the first-fit allocator
// no dependencies
`timescale 1ns / 1ps
package ffa_pkg;

	localparam int SIZE_W = 11;
	localparam int ADDR_W = 10;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] block_start;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] alloc_start;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHDN,
		S_SHUP,
		S_DONE
	} state_t;

endpackage

// File: design/ffa_if.sv
// valid/ready channels for requests and responses of the allocator
// depends on ffa_pkg
`timescale 1ns / 1ps
interface ffa_req_if;
	import ffa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ffa_rsp_if;
	import ffa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/first_fit_free_list_allocator_top.sv
// first-fit free-extent allocator with coalescing, top level
// depends on ffa_pkg, ffa_if.sv and first_fit_free_list_allocator_top_assert.svh
//
// usage: requests enter on req (mode, req_size, block_start), one response per
// request leaves on rsp (status, alloc_start, free_count). a transaction moves
// when valid and ready are both high.
// one request is handled at a time; req.ready is high only while the sequencer
// is idle. the extent table sits in a single memory with one write and one
// registered read port, so the scan reads one extent per cycle and a table
// shift moves one extent per cycle, right behind the scan.
// steps: an ignored free goes straight to the response. otherwise the scan
// runs; a split or a miss then answers, a free passes through a decide step that
// merges or reports a full table, and an exact fit, an insert or a two-sided
// merge shifts the table first. req.ready returns as the response is registered.
// the response sits in an output register; a new request is taken while it
// waits, and the next response waits in the sequencer until rsp is taken.
// reset: asynchronous, the table holds one extent covering all MEM_UNITS units;
// no clearing pass is needed, the block is ready right after reset.
`timescale 1ns / 1ps
`include "first_fit_free_list_allocator_top_assert.svh"
module first_fit_free_list_allocator_top #(
	parameter int MEM_UNITS   = 1024,
	parameter int MAX_EXTENTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ffa_req_if.sink      req,
	ffa_rsp_if.source    rsp
);
	import ffa_pkg::*;

	localparam int AW = $clog2(MEM_UNITS);
	localparam int SW = $clog2(MEM_UNITS + 1);
	localparam int CW = ((SW > SIZE_W) ? SW : SIZE_W) + 1;
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int NW = $clog2(MAX_EXTENTS + 1);
	localparam int OW = (AW > ADDR_W) ? AW : ADDR_W;
	localparam int KW = (NW > CNT_W) ? NW : CNT_W;
	localparam int EW = AW + SW;
	localparam logic [CW-1:0] MEM_C = CW'(MEM_UNITS);
	localparam logic [SW-1:0] MEM_S = SW'(MEM_UNITS);
	localparam logic [NW-1:0] MAX_N = NW'(MAX_EXTENTS);

	// extent table, {start, size} per entry
	logic [EW-1:0] tbl_q [MAX_EXTENTS];
	logic [EW-1:0] rdata_q;

	state_t state_q, state_d;
	logic [NW-1:0] count_q, count_d;
	logic [NW-1:0] iss_q, iss_d;
	logic          e0_fresh_q, e0_fresh_d;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          fresh_s1;
	logic          rsp_valid_q, rsp_valid_d;
	rsp_t          rsp_q, rsp_d;

	logic              mode_q, mode_d;
	logic [CW-1:0]     size_q, size_d;
	logic [AW-1:0]     s_q, s_d;
	logic [SW-1:0]     send_q, send_d;
	logic [NW-1:0]     pos_q, pos_d;
	logic [AW-1:0]     prv_start_q, prv_start_d;
	logic [SW-1:0]     prv_size_q, prv_size_d;
	logic              prv_touch_q, prv_touch_d;
	logic [SW-1:0]     nxt_size_q, nxt_size_d;
	logic              nxt_touch_q, nxt_touch_d;
	logic [AW-1:0]     where_q, where_d;
	logic [STAT_W-1:0] status_q, status_d;

	logic          rd_en;
	logic [IW-1:0] raddr;
	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;

	logic [EW-1:0] ent;
	logic [AW-1:0] e_start;
	logic [SW-1:0] e_size;
	logic [CW-1:0] in_s_c, in_sz_c, room_c, sum_c, clip_c, send_c;
	logic          ignore_c;
	logic [CW-1:0] st_add, sz_sub;
	logic [SW-1:0] prev_end;
	logic          fit, exact, lt;
	logic          scan_issue, up_issue;
	logic [NW-1:0] iss_m1, pos_m1;
	logic [SW-1:0] sz_sw;
	logic [OW-1:0] where_ext;
	logic [KW-1:0] cnt_ext;

	// request decode, done in the transaction cycle
	assign in_s_c   = CW'(req.data.block_start);
	assign in_sz_c  = CW'(req.data.req_size);
	assign room_c   = MEM_C - in_s_c;
	assign sum_c    = in_s_c + in_sz_c;
	assign clip_c   = (in_sz_c > room_c) ? room_c : in_sz_c;
	assign send_c   = (in_sz_c > room_c) ? MEM_C : sum_c;
	assign ignore_c = (req.data.req_size == '0) || (in_s_c >= MEM_C);

	// entry 0 reads as the full-memory extent until first written
	assign ent     = fresh_s1 ? {{AW{1'b0}}, MEM_S} : rdata_q;
	assign e_start = ent[EW-1:SW];
	assign e_size  = ent[SW-1:0];

	assign st_add   = CW'(e_start) + size_q;
	assign sz_sub   = CW'(e_size) - size_q;
	assign prev_end = SW'(e_start) + e_size;
	assign fit      = CW'(e_size) >= size_q;
	assign exact    = CW'(e_size) == size_q;
	assign lt       = e_start < s_q;
	assign sz_sw    = size_q[SW-1:0];

	assign scan_issue = iss_q < count_q;
	assign up_issue   = iss_q > pos_q;
	assign iss_m1     = iss_q - NW'(1);
	assign pos_m1     = pos_q - NW'(1);

	assign where_ext = OW'(where_q);
	assign cnt_ext   = KW'(count_q);

	assign e0_fresh_d = e0_fresh_q && !(we && (waddr == '0));

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		iss_d       = iss_q;
		rd_en       = 1'b0;
		raddr       = iss_q[IW-1:0];
		we          = 1'b0;
		waddr       = idx_s1;
		wdata       = ent;
		mode_d      = mode_q;
		size_d      = size_q;
		s_d         = s_q;
		send_d      = send_q;
		pos_d       = pos_q;
		prv_start_d = prv_start_q;
		prv_size_d  = prv_size_q;
		prv_touch_d = prv_touch_q;
		nxt_size_d  = nxt_size_q;
		nxt_touch_d = nxt_touch_q;
		where_d     = where_q;
		status_d    = status_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		rsp_d       = rsp_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					mode_d      = req.data.mode;
					s_d         = in_s_c[AW-1:0];
					send_d      = send_c[SW-1:0];
					prv_touch_d = 1'b0;
					nxt_touch_d = 1'b0;
					where_d     = '0;
					status_d    = ST_OK;
					iss_d       = '0;
					if (req.data.mode == MODE_ALLOC) begin
						size_d  = in_sz_c;
						state_d = S_SCAN;
					end else begin
						size_d  = clip_c;
						state_d = ignore_c ? S_DONE : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (v_s1 && (mode_q == MODE_ALLOC) && fit) begin
					where_d = e_start;
					if (exact) begin
						iss_d   = NW'(idx_s1) + NW'(1);
						state_d = S_SHDN;
					end else begin
						// split from the low end
						we      = 1'b1;
						waddr   = idx_s1;
						wdata   = {st_add[AW-1:0], sz_sub[SW-1:0]};
						state_d = S_DONE;
					end
				end else if (v_s1 && (mode_q == MODE_FREE) && !lt) begin
					pos_d       = NW'(idx_s1);
					nxt_size_d  = e_size;
					nxt_touch_d = SW'(e_start) == send_q;
					state_d     = S_DECIDE;
				end else begin
					if (v_s1 && (mode_q == MODE_FREE)) begin
						prv_start_d = e_start;
						prv_size_d  = e_size;
						prv_touch_d = prev_end == SW'(s_q);
					end
					if (scan_issue) begin
						rd_en = 1'b1;
						iss_d = iss_q + NW'(1);
					end else if (!v_s1) begin
						// table exhausted
						if (mode_q == MODE_ALLOC) begin
							status_d = ST_NOFIT;
							state_d  = S_DONE;
						end else begin
							pos_d   = count_q;
							state_d = S_DECIDE;
						end
					end
				end
			end
			S_DECIDE: begin
				if (prv_touch_q && nxt_touch_q) begin
					we      = 1'b1;
					waddr   = pos_m1[IW-1:0];
					wdata   = {prv_start_q, prv_size_q + sz_sw + nxt_size_q};
					iss_d   = pos_q + NW'(1);
					state_d = S_SHDN;
				end else if (prv_touch_q) begin
					we      = 1'b1;
					waddr   = pos_m1[IW-1:0];
					wdata   = {prv_start_q, prv_size_q + sz_sw};
					state_d = S_DONE;
				end else if (nxt_touch_q) begin
					we      = 1'b1;
					waddr   = pos_q[IW-1:0];
					wdata   = {s_q, nxt_size_q + sz_sw};
					state_d = S_DONE;
				end else if (count_q >= MAX_N) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					iss_d   = count_q;
					state_d = S_SHUP;
				end
			end
			S_SHDN: begin
				// close the gap: entry j moves to j - 1
				if (v_s1) begin
					we    = 1'b1;
					waddr = idx_s1 - IW'(1);
				end
				if (scan_issue) begin
					rd_en = 1'b1;
					iss_d = iss_q + NW'(1);
				end else if (!v_s1) begin
					count_d = count_q - NW'(1);
					state_d = S_DONE;
				end
			end
			S_SHUP: begin
				// open a slot: entry j moves to j + 1, from the top down
				raddr = iss_m1[IW-1:0];
				if (v_s1) begin
					we    = 1'b1;
					waddr = idx_s1 + IW'(1);
				end
				if (up_issue) begin
					rd_en = 1'b1;
					iss_d = iss_m1;
				end else if (!v_s1) begin
					we      = 1'b1;
					waddr   = pos_q[IW-1:0];
					wdata   = {s_q, sz_sw};
					count_d = count_q + NW'(1);
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d       = 1'b1;
					rsp_d.status      = status_q;
					rsp_d.alloc_start = where_ext[ADDR_W-1:0];
					rsp_d.free_count  = cnt_ext[CNT_W-1:0];
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= NW'(1);
			e0_fresh_q  <= 1'b1;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			e0_fresh_q  <= e0_fresh_d;
			v_s1        <= rd_en;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		iss_q       <= iss_d;
		idx_s1      <= raddr;
		fresh_s1    <= e0_fresh_q && (raddr == '0);
		rsp_q       <= rsp_d;
		mode_q      <= mode_d;
		size_q      <= size_d;
		s_q         <= s_d;
		send_q      <= send_d;
		pos_q       <= pos_d;
		prv_start_q <= prv_start_d;
		prv_size_q  <= prv_size_d;
		prv_touch_q <= prv_touch_d;
		nxt_size_q  <= nxt_size_d;
		nxt_touch_q <= nxt_touch_d;
		where_q     <= where_d;
		status_q    <= status_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tbl_q[waddr] <= wdata;
		end
		rdata_q <= tbl_q[raddr];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	`FFA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_N)
	`FFA_ASSERT_NXT(a_count_step, clk, arst_n, 1'b1, (count_q - $past(count_q) + NW'(1)) <= NW'(2))
	`FFA_ASSERT_IMP(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !we)
	`FFA_ASSERT_NXT(a_accept_busy, clk, arst_n, req.valid && req.ready, state_q != S_IDLE)
	`FFA_ASSERT_IMP(a_shup_room, clk, arst_n, state_q == S_SHUP, count_q < MAX_N)

endmodule

// File: tb/tb_top.sv
// self-checking bench for first_fit_free_list_allocator_top: directed and random
// allocate/free traffic, responses compared against a behavioral extent table
// depends on ffa_pkg, ffa_if.sv and the allocator rtl
`timescale 1ns / 1ps
module tb_top;
	import ffa_pkg::*;

	localparam int MEM     = 1024;
	localparam int MAX_EXT = 16;
	localparam int PRINT_CAP = 50;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	typedef struct {
		int base;
		int len;
	} span_t;

	logic clk = 1'b0;
	logic arst_n;

	ffa_req_if req_ch();
	ffa_rsp_if rsp_ch();

	first_fit_free_list_allocator_top #(
		.MEM_UNITS(MEM),
		.MAX_EXTENTS(MAX_EXT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #2 clk = ~clk;

	// expected copy of the free-extent table, sorted by start address
	bit [ADDR_W-1:0] free_base [MAX_EXT];
	bit [SIZE_W-1:0] free_len [MAX_EXT];
	int free_cnt;

	rsp_t pending_rsp [$];
	span_t held [$];
	int err_count = 0;
	int burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("tb_top: %0t mismatch on %s, got %0d want %0d", $realtime, what, got, want);
	endtask

	function automatic void remove_extent(input int pos);
		for (int i = pos; i + 1 < free_cnt; i++) begin
			free_base[i] = free_base[i + 1];
			free_len[i] = free_len[i + 1];
		end
		free_cnt--;
	endfunction

	// applies one request to the table copy and returns the response it must give
	function automatic rsp_t predict_response(input req_t r);
		rsp_t o;
		int s;
		int len;
		int pos;
		bit found;
		bit joins_lo;
		bit joins_hi;
		o = '0;
		if (r.mode == MODE_ALLOC) begin
			o.status = ST_NOFIT;
			found = 1'b0;
			for (int i = 0; i < free_cnt; i++) begin
				if (!found && free_len[i] >= r.req_size) begin
					found = 1'b1;
					o.status = ST_OK;
					o.alloc_start = free_base[i];
					if (free_len[i] == r.req_size) begin
						remove_extent(i);
					end else begin
						free_base[i] = ADDR_W'(free_base[i] + r.req_size);
						free_len[i] = free_len[i] - r.req_size;
					end
				end
			end
		end else begin
			o.status = ST_OK;
			s = int'(r.block_start);
			len = int'(r.req_size);
			if (len != 0 && s < MEM) begin
				if (len > MEM - s)
					len = MEM - s;
				pos = 0;
				while (pos < free_cnt && free_base[pos] < s)
					pos++;
				joins_lo = (pos > 0) ? (free_base[pos - 1] + free_len[pos - 1] == s) : 1'b0;
				joins_hi = (pos < free_cnt) ? (s + len == free_base[pos]) : 1'b0;
				if (joins_lo && joins_hi) begin
					free_len[pos - 1] = SIZE_W'(free_len[pos - 1] + len + free_len[pos]);
					remove_extent(pos);
				end else if (joins_lo) begin
					free_len[pos - 1] = SIZE_W'(free_len[pos - 1] + len);
				end else if (joins_hi) begin
					free_base[pos] = ADDR_W'(s);
					free_len[pos] = SIZE_W'(free_len[pos] + len);
				end else if (free_cnt >= MAX_EXT) begin
					o.status = ST_FULL;
				end else begin
					for (int i = free_cnt; i > pos; i--) begin
						free_base[i] = free_base[i - 1];
						free_len[i] = free_len[i - 1];
					end
					free_base[pos] = ADDR_W'(s);
					free_len[pos] = SIZE_W'(len);
					free_cnt++;
				end
			end
		end
		o.free_count = free_cnt[CNT_W-1:0];
		return o;
	endfunction

	// sends one request in bursts with random gaps, predicts on the transaction
	task automatic send_req(input logic mode, input int size, input int bs, output rsp_t predicted);
		req_t r;
		int gap;
		r.mode = mode;
		r.req_size = size[SIZE_W-1:0];
		r.block_start = bs[ADDR_W-1:0];
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_response(r);
		pending_rsp.push_back(predicted);
	endtask

	// whole-memory allocate, empty table, ignored free
	task automatic test_reset_extremes();
		rsp_t p;
		send_req(MODE_ALLOC, 0, 1023, p);
		send_req(MODE_ALLOC, MEM, 0, p);
		send_req(MODE_ALLOC, 0, 512, p);
		send_req(MODE_FREE, 0, 700, p);
	endtask

	// fill all sixteen extents, then overflow, merges at full and same-start insert
	task automatic test_table_full();
		rsp_t p;
		send_req(MODE_FREE, MEM, 1000, p);
		for (int i = 0; i < 15; i++)
			send_req(MODE_FREE, 30, 60 * ((i * 7) % 15), p);
		send_req(MODE_FREE, 10, 900, p);
		send_req(MODE_FREE, 30, 30, p);
		send_req(MODE_FREE, 5, 120, p);
		send_req(MODE_FREE, 30, 90, p);
	endtask

	// no extent large enough, then a split from the low end
	task automatic test_alloc_fit();
		rsp_t p;
		send_req(MODE_ALLOC, 1023, 1023, p);
		send_req(MODE_ALLOC, 30, 341, p);
	endtask

	// mostly allocate/free pairs on live blocks, with stray and broken frees
	task automatic test_random_traffic(input int n);
		rsp_t p;
		span_t sp;
		int pick;
		int k;
		int sz;
		int bs;
		for (int it = 0; it < n; it++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 || (pick < 88 && held.size() == 0)) begin
				k = $urandom_range(0, 15);
				if (k == 0)
					sz = 0;
				else if (k == 1)
					sz = $urandom_range(512, MEM);
				else
					sz = $urandom_range(1, 96);
				send_req(MODE_ALLOC, sz, $urandom_range(0, 1023), p);
				if (p.status == ST_OK && sz != 0) begin
					sp.base = int'(p.alloc_start);
					sp.len = sz;
					held.push_back(sp);
				end
			end else if (pick < 88) begin
				k = $urandom_range(0, held.size() - 1);
				sp = held[k];
				held.delete(k);
				send_req(MODE_FREE, sp.len, sp.base, p);
			end else begin
				bs = $urandom_range(0, 1023);
				case ($urandom_range(0, 3))
					0: sz = 0;
					1: sz = MEM - bs + $urandom_range(0, 64);
					2: sz = $urandom_range(1, 64);
					default: sz = $urandom_range(0, MEM);
				endcase
				if (sz > MEM)
					sz = MEM;
				send_req(MODE_FREE, sz, bs, p);
			end
		end
	endtask

	// receiver ready pattern: stretches of always-ready, coin flips, heavy stall, toggling
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(16, 96);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE: rsp_ch.ready <= 1'b1;
				STALL_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
				STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= ~rsp_ch.ready;
			endcase
		end
	end

	// compare each response transaction with the oldest prediction
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.status !== want.status)
					report_mismatch("status", int'(rsp_ch.data.status), int'(want.status));
				if (rsp_ch.data.alloc_start !== want.alloc_start)
					report_mismatch("alloc_start", int'(rsp_ch.data.alloc_start),
						int'(want.alloc_start));
				if (rsp_ch.data.free_count !== want.free_count)
					report_mismatch("free_count", int'(rsp_ch.data.free_count),
						int'(want.free_count));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < MAX_EXT; i++) begin
			free_base[i] = '0;
			free_len[i] = '0;
		end
		free_len[0] = SIZE_W'(MEM);
		free_cnt = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_extremes();
		test_table_full();
		test_alloc_fit();
		test_random_traffic(725);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		// drain: longest shift sequence plus margin
		repeat (64) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/ffa_pkg.sv
design/ffa_if.sv
design/first_fit_free_list_allocator_top.sv
tb/tb_top.sv
